### rtl/core/tfw_pkg.sv
package tfw_pkg;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // datapath commands from the controller
  typedef struct packed {
    logic capture;    // latch the query fields
    logic load;       // write one edge
    logic clear;      // empty the store
    logic rd_start;   // restart the edge read pointer
    logic rd_next;    // advance the read pointer
    logic near_step;  // fold the edge at the pipeline end into the nearest search
    logic proj;       // extrapolate to the chosen edge
    logic wind_step;  // fold the edge at the pipeline end into the winding sum
    logic emit;       // capture the result
  } tfw_cmd_t;

  // datapath status to the controller
  typedef struct packed {
    logic empty;
    logic rd_last;    // read pointer at the last stored edge
  } tfw_stat_t;

endpackage

### rtl/core/tfw_ctrl.sv
module tfw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tfw_pkg::tfw_stat_t stat,
  output tfw_pkg::tfw_cmd_t  cmd
);
  import tfw_pkg::*;

  // pipeline depth between a read request and the step at its end
  localparam int PIPE = 5;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_NEAR  = 7'b0000010,
    S_DRN1  = 7'b0000100,
    S_PROJ  = 7'b0001000,
    S_WIND  = 7'b0010000,
    S_DRN2  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [PIPE-1:0] vpipe;
  logic issue;
  logic [2:0] drain, drain_next;

  assign in_ready = (state == S_IDLE) && !(out_valid && !out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    drain_next = drain;
    issue = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          case (in_op)
            OP_CLEAR: cmd.clear = 1'b1;
            OP_LOAD:  cmd.load = 1'b1;
            OP_QUERY: begin
              cmd.rd_start = 1'b1;
              if (stat.empty) state_next = S_EMIT;
              else state_next = S_NEAR;
            end
            default: ;
          endcase
        end
      end
      S_NEAR, S_WIND: begin
        issue = 1'b1;
        if (stat.rd_last) begin
          state_next = (state == S_NEAR) ? S_DRN1 : S_DRN2;
          drain_next = 3'(PIPE);
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_DRN1, S_DRN2: begin
        drain_next = drain - 3'd1;
        if (drain == 3'd1) begin
          if (state == S_DRN1) begin
            state_next = S_PROJ;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_PROJ: begin
        cmd.proj = 1'b1;
        cmd.rd_start = 1'b1;
        state_next = S_WIND;
      end
      S_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    cmd.near_step = vpipe[PIPE-1] && (state == S_NEAR || state == S_DRN1);
    cmd.wind_step = vpipe[PIPE-1] && (state == S_WIND || state == S_DRN2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vpipe <= '0;
      drain <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      drain <= drain_next;
      vpipe <= {vpipe[PIPE-2:0], issue};
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // a result never comes out of an idle controller
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> state == S_EMIT)
    else $error("emit outside emit state");
  // input is held off while a query runs
  assert property (@(posedge clk) disable iff (rst) state != S_IDLE |-> !in_ready)
    else $error("ready during query");
  // no edge reaches the end of the pipe after draining
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PROJ || state == S_EMIT) |-> !vpipe[PIPE-1])
    else $error("pipeline not drained");

endmodule

### rtl/core/tfw_dp.sv
module tfw_dp #(
  parameter int MAX_EDGES  = 64,
  parameter int SLOPE_FRAC = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  tfw_pkg::tfw_cmd_t  cmd,
  output tfw_pkg::tfw_stat_t stat,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] start_x,
  input  logic signed [31:0] start_y,
  input  logic signed [31:0] start_z,
  input  logic signed [31:0] end_x,
  input  logic signed [31:0] end_y,
  input  logic signed [31:0] track_x,
  input  logic signed [31:0] track_y,
  input  logic signed [31:0] track_z,
  input  logic signed [20:0] slope_x,
  input  logic signed [20:0] slope_y,
  output logic               inside_res,
  output logic signed [7:0]  winding,
  output logic signed [31:0] proj_x,
  output logic signed [31:0] proj_y,
  output logic [1:0]         status
);
  import tfw_pkg::*;

  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int WW = CW + 1;

  // edge store
  logic signed [31:0] mem_sx [MAX_EDGES];
  logic signed [31:0] mem_sy [MAX_EDGES];
  logic signed [31:0] mem_sz [MAX_EDGES];
  logic signed [31:0] mem_ex [MAX_EDGES];
  logic signed [31:0] mem_ey [MAX_EDGES];
  logic [CW-1:0] total;
  logic dropped;
  logic [AW-1:0] rptr;

  // query registers
  logic signed [31:0] tx, ty, tz;
  logic signed [20:0] ax, ay;
  logic signed [31:0] px, py;

  assign stat.empty = (total == '0);
  assign stat.rd_last = (CW'(rptr) == total - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      dropped <= 1'b0;
    end else if (cmd.clear) begin
      total <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (total < CW'(MAX_EDGES)) total <= total + CW'(1);
      else dropped <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && total < CW'(MAX_EDGES)) begin
      mem_sx[total[AW-1:0]] <= start_x;
      mem_sy[total[AW-1:0]] <= start_y;
      mem_sz[total[AW-1:0]] <= start_z;
      mem_ex[total[AW-1:0]] <= end_x;
      mem_ey[total[AW-1:0]] <= end_y;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && in_op == OP_QUERY) begin
      tx <= track_x; ty <= track_y; tz <= track_z;
      ax <= slope_x; ay <= slope_y;
    end
    if (cmd.rd_start) rptr <= '0;
    else if (cmd.rd_next) rptr <= rptr + AW'(1);
  end

  // stage 1: registered memory read
  logic signed [31:0] r_sx, r_sy, r_sz, r_ex, r_ey;
  always_ff @(posedge clk) begin
    r_sx <= mem_sx[rptr]; r_sy <= mem_sy[rptr]; r_sz <= mem_sz[rptr];
    r_ex <= mem_ex[rptr]; r_ey <= mem_ey[rptr];
  end

  // extrapolation helper: pos + floor(prod / 2^SLOPE_FRAC), saturated
  function automatic logic signed [31:0] ext_fin(logic signed [31:0] pos,
                                                 logic signed [53:0] prod);
    logic signed [54:0] s;
    begin
      s = 55'(pos) + 55'(prod >>> SLOPE_FRAC);
      if (s > 55'sd2147483647) ext_fin = 32'sh7fffffff;
      else if (s < -55'sd2147483648) ext_fin = 32'sh80000000;
      else ext_fin = s[31:0];
    end
  endfunction

  // stage 2: dz, stage 3: slope products (21 x 33)
  logic signed [32:0] s2_dz;
  logic signed [31:0] s2_sx, s2_sy, s2_ex, s2_ey;
  logic signed [53:0] s3_mx, s3_my;
  logic signed [31:0] s3_sx, s3_sy, s3_ex, s3_ey;
  always_ff @(posedge clk) begin
    s2_dz <= 33'(r_sz) - 33'(tz);
    s2_sx <= r_sx; s2_sy <= r_sy; s2_ex <= r_ex; s2_ey <= r_ey;
    s3_mx <= 54'(ax) * 54'(s2_dz);
    s3_my <= 54'(ay) * 54'(s2_dz);
    s3_sx <= s2_sx; s3_sy <= s2_sy; s3_ex <= s2_ex; s3_ey <= s2_ey;
  end

  // stage 4: extrapolated point and differences
  logic signed [31:0] s4_x, s4_y, s4_sy, s4_ey;
  logic [32:0] s4_dx, s4_dy;
  // winding differences
  logic signed [32:0] s4_a1, s4_a2, s4_b1, s4_b2;
  logic signed [31:0] ex4, ey4;
  logic signed [32:0] d4x, d4y;
  always_comb begin
    ex4 = ext_fin(tx, s3_mx);
    ey4 = ext_fin(ty, s3_my);
    d4x = 33'(ex4) - 33'(s3_sx);
    d4y = 33'(ey4) - 33'(s3_sy);
  end
  always_ff @(posedge clk) begin
    s4_x <= ex4; s4_y <= ey4;
    s4_dx <= d4x[32] ? 33'(-d4x) : d4x;
    s4_dy <= d4y[32] ? 33'(-d4y) : d4y;
    s4_sy <= s3_sy; s4_ey <= s3_ey;
    s4_a1 <= 33'(px) - 33'(s3_sx);
    s4_a2 <= 33'(s3_ey) - 33'(s3_sy);
    s4_b1 <= 33'(py) - 33'(s3_sy);
    s4_b2 <= 33'(s3_ex) - 33'(s3_sx);
  end

  // stage 5: squares and cross products
  logic [64:0] s5_dist;
  logic signed [31:0] s5_x, s5_y;
  logic signed [65:0] s5_lhs, s5_rhs;
  logic s5_up, s5_dn;
  always_ff @(posedge clk) begin
    s5_dist <= 65'(s4_dx) * 65'(s4_dx) + 65'(s4_dy) * 65'(s4_dy);
    s5_x <= s4_x; s5_y <= s4_y;
    s5_lhs <= 66'(s4_a1) * 66'(s4_a2);
    s5_rhs <= 66'(s4_b1) * 66'(s4_b2);
    s5_up <= (s4_sy <= py) && (s4_ey > py);
    s5_dn <= (s4_sy > py) && (s4_ey <= py);
  end

  // nearest search, keeps the extrapolated point of the best edge
  logic [64:0] best_d;
  logic signed [31:0] best_x, best_y;
  logic first;
  always_ff @(posedge clk) begin
    if (cmd.rd_start) first <= 1'b1;
    else if (cmd.near_step) first <= 1'b0;
    if (cmd.near_step && (first || s5_dist < best_d)) begin
      best_d <= s5_dist;
      best_x <= s5_x;
      best_y <= s5_y;
    end
  end

  // projection to the chosen edge
  logic proj_d;
  always_ff @(posedge clk) begin
    if (rst) proj_d <= 1'b0;
    else proj_d <= cmd.proj;
    if (cmd.proj) begin
      px <= best_x;
      py <= best_y;
    end
  end

  // winding accumulation
  logic signed [WW-1:0] wn;
  always_ff @(posedge clk) begin
    if (cmd.rd_start) wn <= '0;
    else if (cmd.wind_step) begin
      if (s5_up && s5_lhs < s5_rhs) wn <= wn + WW'(1);
      else if (s5_dn && s5_rhs < s5_lhs) wn <= wn - WW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (total == '0) begin
        inside_res <= 1'b0; winding <= '0;
        proj_x <= tx; proj_y <= ty; status <= ST_EMPTY;
      end else begin
        inside_res <= !wn[WW-1] && (wn != '0);
        winding <= 8'(wn);
        proj_x <= px; proj_y <= py;
        status <= dropped ? ST_DROPPED : ST_OK;
      end
    end
  end

  // store count never exceeds capacity
  assert property (@(posedge clk) disable iff (rst) total <= CW'(MAX_EDGES))
    else $error("edge count overflow");
  // projection is never taken from an empty store
  assert property (@(posedge clk) disable iff (rst) cmd.proj |-> total != '0)
    else $error("projection on empty store");
  // the product pipeline has settled when the projection is taken
  assert property (@(posedge clk) disable iff (rst) proj_d |-> !cmd.wind_step)
    else $error("winding step too early");

endmodule

### rtl/core/track_fiducial_winding_test_top.sv
// Point-in-polygon test of a track against one stored fiducial polygon.
// Operation 0 clears the edge store, 1 loads one edge (dropped and flagged
// once MAX_EDGES are held), 2 queries a track and yields one result. A
// query sweeps the single memory read port once for the nearest start
// point and once for the winding sum, each through a five-stage
// extrapolate and multiply pipeline. An empty store answers with status 1.
module track_fiducial_winding_test_top #(
  parameter int MAX_EDGES  = 64,
  parameter int SLOPE_FRAC = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op[1:0], start_x, start_y, start_z, end_x, end_y, track_x, track_y,
  // track_z (32 each from bit 2), slope_x[278:258], slope_y[299:279], zero pad
  input  logic [303:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // inside_res[0], winding[8:1], proj_x[40:9], proj_y[72:41], status[74:73]
  output logic [79:0]  m_tdata
);
  import tfw_pkg::*;

  tfw_cmd_t  cmd;
  tfw_stat_t stat;
  logic              inside_res;
  logic signed [7:0] winding;
  logic signed [31:0] proj_x, proj_y;
  logic [1:0] status;

  tfw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_op(s_tdata[1:0]),
    .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
    .stat(stat), .cmd(cmd)
  );

  tfw_dp #(.MAX_EDGES(MAX_EDGES), .SLOPE_FRAC(SLOPE_FRAC)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_op(s_tdata[1:0]),
    .start_x(s_tdata[33:2]), .start_y(s_tdata[65:34]), .start_z(s_tdata[97:66]),
    .end_x(s_tdata[129:98]), .end_y(s_tdata[161:130]),
    .track_x(s_tdata[193:162]), .track_y(s_tdata[225:194]),
    .track_z(s_tdata[257:226]), .slope_x(s_tdata[278:258]),
    .slope_y(s_tdata[299:279]),
    .inside_res(inside_res), .winding(winding), .proj_x(proj_x),
    .proj_y(proj_y), .status(status)
  );

  assign m_tdata = {5'd0, status, proj_y, proj_x, winding, inside_res};

endmodule
